// ===== hdl/dhkvt_pkg.sv =====
// Shared types, constants and codes of the double-hash key-value table
package dhkvt_pkg;

  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned KEY_BYTES_DEF   = 8;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned KEY_LEN_W = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STAT_W    = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic clr;
    logic start;
    logic hash_step;
    logic div_step;
    logic early;
    logic chk;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_done;
    logic div_last;
    logic early_end;
    logic chk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/dhkvt_ctrl.sv =====
// Sequencer of the double-hash key-value table: clear, hash, divide, probe, answer
module dhkvt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dhkvt_pkg::dp_stat_t  stat_i,
  output dhkvt_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] CS_CLR  = 3'd0;
  localparam logic [2:0] CS_IDLE = 3'd1;
  localparam logic [2:0] CS_HASH = 3'd2;
  localparam logic [2:0] CS_DIV  = 3'd3;
  localparam logic [2:0] CS_PRD  = 3'd4;
  localparam logic [2:0] CS_PCHK = 3'd5;
  localparam logic [2:0] CS_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      CS_CLR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = CS_IDLE;
      end
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = CS_HASH;
        end
      end
      CS_HASH: begin
        if (stat_i.hash_done) state_d = CS_DIV;
        else cmd_o.hash_step = 1'b1;
      end
      CS_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          if (stat_i.early_end) begin
            cmd_o.early = 1'b1;
            state_d     = CS_DONE;
          end else begin
            state_d = CS_PRD;
          end
        end
      end
      CS_PRD: begin
        state_d = CS_PCHK;
      end
      CS_PCHK: begin
        cmd_o.chk = 1'b1;
        state_d   = stat_i.chk_done ? CS_DONE : CS_PRD;
      end
      CS_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == CS_IDLE);

`ifndef SYNTHESIS
  a_start_hash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == CS_HASH)
    else $error("word accepted without entering hash phase");
  a_chk_after_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_PCHK |-> $past(state_q) == CS_PRD)
    else $error("probe check without prior read");
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> stat_i.out_free)
    else $error("output register overwritten");
`endif

endmodule

// ===== hdl/dhkvt_dp.sv =====
// Datapath of the double-hash key-value table: hash, remainders, slot memory, output register
module dhkvt_dp #(
  parameter int unsigned DEPTH       = dhkvt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BYTES   = dhkvt_pkg::KEY_BYTES_DEF,
  parameter int unsigned VALUE_WIDTH = dhkvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dhkvt_pkg::SIZE_W-1:0]         cfg_wdata_i,
  input  logic [dhkvt_pkg::OP_W-1:0]           opcode_i,
  input  logic [dhkvt_pkg::KEY_W-1:0]          key_i,
  input  logic [dhkvt_pkg::KEY_LEN_W-1:0]      key_len_i,
  input  logic [dhkvt_pkg::VAL_W-1:0]          value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dhkvt_pkg::STAT_W-1:0]         status_o,
  output logic [dhkvt_pkg::VAL_W-1:0]          value_out_o,
  output logic [dhkvt_pkg::SIZE_W-1:0]         live_count_o,
  input  dhkvt_pkg::ctrl_cmd_t                 cmd_i,
  output dhkvt_pkg::dp_stat_t                  stat_o
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned SW  = dhkvt_pkg::SIZE_W;
  localparam int unsigned KW  = dhkvt_pkg::KEY_W;
  localparam int unsigned LW  = dhkvt_pkg::KEY_LEN_W;
  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned EW  = KW + LW + VW + 2;
  localparam int unsigned VLO = 2;
  localparam int unsigned LLO = 2 + VW;
  localparam int unsigned KLO = 2 + VW + LW;

  function automatic logic [63:0] pjw_step(logic [63:0] h, logic [7:0] c);
    logic [63:0] t;
    t = {h[55:0], 8'h00} + {{56{c[7]}}, c};
    if (t[63:56] != 8'h00) begin
      t = (t ^ {48'h0, t[63:56], 8'h00}) & 64'h00FF_FFFF_FFFF_FFFF;
    end
    return t;
  endfunction

  logic [SW-1:0]                   tsize_q;
  logic [dhkvt_pkg::OP_W-1:0]      op_q;
  logic [KW-1:0]                   key_in_q;
  logic [LW-1:0]                   n_q;
  logic [VW-1:0]                   val_q;
  logic [KW-1:0]                   kv_q;
  logic [LW-1:0]                   len_q;
  logic [LW-1:0]                   byte_q;
  logic [63:0]                     h_q;
  logic [3:0]                      div_cnt_q;
  logic [SW-1:0]                   s_q;
  logic [SW-1:0]                   pos_q;
  logic [SW-1:0]                   rb_q;
  logic [SW-1:0]                   probe_q;
  logic [SW-1:0]                   count_q;
  logic [AW-1:0]                   clr_q;
  logic [dhkvt_pkg::STAT_W-1:0]    res_stat_q;
  logic [VW-1:0]                   res_val_q;
  logic                            out_valid_q;
  logic [dhkvt_pkg::STAT_W-1:0]    status_q;
  logic [dhkvt_pkg::VAL_W-1:0]     vout_q;
  logic [SW-1:0]                   live_q;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;

  logic [SW-1:0]   eff_size;
  logic [LW-1:0]   n_clamp;
  logic [7:0]      cur_byte;
  logic [SW-1:0]   m2;
  logic [SW-1:0]   ra, rb;
  logic [SW:0]     ta, tb;
  logic [SW:0]     sum;
  logic [SW-1:0]   pos_next;
  logic            probe_last;
  logic            r_act, r_used, r_match, is_ins;
  logic [VW-1:0]   r_val;
  logic            chk_done;
  logic            chk_we;
  logic [EW-1:0]   chk_wdata;
  logic [dhkvt_pkg::STAT_W-1:0] chk_stat;
  logic [VW-1:0]   chk_val;
  logic            cnt_inc, cnt_dec;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;

  always_comb begin
    if (32'(tsize_q) > 32'(DEPTH)) eff_size = SW'(DEPTH);
    else if (tsize_q < dhkvt_pkg::SIZE_MIN) eff_size = dhkvt_pkg::SIZE_MIN;
    else eff_size = tsize_q;
  end

  assign n_clamp  = (32'(key_len_i) > 32'(KEY_BYTES)) ? LW'(KEY_BYTES) : key_len_i;
  assign cur_byte = key_in_q[{byte_q[2:0], 3'b000} +: 8];
  assign m2       = s_q - SW'(2);

  always_comb begin
    ra = pos_q;
    rb = rb_q;
    ta = '0;
    tb = '0;
    for (int i = 0; i < 4; i++) begin
      ta = {ra, h_q[63-i]};
      if (ta >= {1'b0, s_q}) ta = ta - {1'b0, s_q};
      ra = ta[SW-1:0];
      tb = {rb, h_q[63-i]};
      if (tb >= {1'b0, m2}) tb = tb - {1'b0, m2};
      rb = tb[SW-1:0];
    end
  end

  assign sum        = {1'b0, pos_q} + {1'b0, rb_q} + (SW+1)'(1);
  assign pos_next   = (sum >= {1'b0, s_q}) ? SW'(sum - {1'b0, s_q}) : sum[SW-1:0];
  assign probe_last = (probe_q == s_q - SW'(1));

  assign r_act   = rdata_q[1];
  assign r_used  = rdata_q[0];
  assign r_val   = rdata_q[VLO +: VW];
  assign r_match = (rdata_q[LLO +: LW] == len_q) && (rdata_q[KLO +: KW] == kv_q);
  assign is_ins  = (op_q == dhkvt_pkg::OP_INSERT);

  always_comb begin
    chk_done  = 1'b0;
    chk_we    = 1'b0;
    chk_wdata = rdata_q;
    chk_stat  = dhkvt_pkg::STAT_MISS;
    chk_val   = '0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    if (is_ins) begin
      if (r_act) begin
        if (r_match) begin
          chk_done             = 1'b1;
          chk_we               = 1'b1;
          chk_wdata[VLO +: VW] = val_q;
          chk_stat             = dhkvt_pkg::STAT_OK;
        end
      end else begin
        chk_done  = 1'b1;
        chk_we    = 1'b1;
        chk_wdata = {kv_q, len_q, val_q, 1'b1, 1'b1};
        chk_stat  = dhkvt_pkg::STAT_OK;
        cnt_inc   = 1'b1;
      end
    end else begin
      if (!r_used) begin
        chk_done = 1'b1;
      end else if (r_match) begin
        chk_done = 1'b1;
        if (r_act) begin
          chk_stat = dhkvt_pkg::STAT_OK;
          chk_val  = r_val;
          if (op_q == dhkvt_pkg::OP_REMOVE) begin
            chk_we       = 1'b1;
            chk_wdata[1] = 1'b0;
            cnt_dec      = (count_q != '0);
          end
        end
      end
    end
    if (!chk_done && probe_last) begin
      chk_done = 1'b1;
      chk_stat = is_ins ? dhkvt_pkg::STAT_FULL : dhkvt_pkg::STAT_MISS;
    end
  end

  assign mem_we    = cmd_i.clr || (cmd_i.chk && chk_we);
  assign mem_waddr = cmd_i.clr ? clr_q : AW'(pos_q);
  assign mem_wdata = cmd_i.clr ? '0 : chk_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[AW'(pos_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q     <= dhkvt_pkg::SIZE_RESET;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) tsize_q <= cfg_wdata_i;
      if (cmd_i.clr) clr_q <= clr_q + AW'(1);
      if (cmd_i.chk && cnt_inc) count_q <= count_q + SW'(1);
      else if (cmd_i.chk && cnt_dec) count_q <= count_q - SW'(1);
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= opcode_i;
      key_in_q  <= key_i;
      n_q       <= n_clamp;
      val_q     <= VW'(value_i);
      kv_q      <= '0;
      len_q     <= '0;
      byte_q    <= '0;
      h_q       <= '0;
      div_cnt_q <= '0;
      s_q       <= eff_size;
      pos_q     <= '0;
      rb_q      <= '0;
      probe_q   <= '0;
    end
    if (cmd_i.hash_step) begin
      h_q                                <= pjw_step(h_q, cur_byte);
      kv_q[{byte_q[2:0], 3'b000} +: 8]   <= cur_byte;
      len_q                              <= len_q + LW'(1);
      byte_q                             <= byte_q + LW'(1);
    end
    if (cmd_i.div_step) begin
      pos_q     <= ra;
      rb_q      <= rb;
      h_q       <= {h_q[59:0], 4'h0};
      div_cnt_q <= div_cnt_q + 4'd1;
    end
    if (cmd_i.early) begin
      res_stat_q <= is_ins ? dhkvt_pkg::STAT_FULL : dhkvt_pkg::STAT_MISS;
      res_val_q  <= '0;
    end
    if (cmd_i.chk) begin
      if (chk_done) begin
        res_stat_q <= chk_stat;
        res_val_q  <= chk_val;
      end else begin
        pos_q   <= pos_next;
        probe_q <= probe_q + SW'(1);
      end
    end
    if (cmd_i.load_out) begin
      status_q <= res_stat_q;
      vout_q   <= dhkvt_pkg::VAL_W'(res_val_q);
      live_q   <= count_q;
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.clr_last  = (clr_q == AW'(DEPTH - 1));
    stat_o.hash_done = (byte_q == n_q) || (cur_byte == 8'h00);
    stat_o.div_last  = (div_cnt_q == 4'd15);
    stat_o.early_end = (is_ins && (count_q >= s_q))
                    || ((op_q == dhkvt_pkg::OP_GET) && (count_q == '0))
                    || (!is_ins && (op_q != dhkvt_pkg::OP_GET)
                        && (op_q != dhkvt_pkg::OP_REMOVE));
    stat_o.chk_done  = chk_done;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign value_out_o  = vout_q;
  assign live_count_o = live_q;

`ifndef SYNTHESIS
  a_probe_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.chk |-> probe_q < s_q)
    else $error("probe count beyond table size");
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.chk |-> pos_q < s_q)
    else $error("probe slot outside table");
  a_clr_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |-> !cmd_i.start && !cmd_i.chk)
    else $error("table access during clearing pass");
`endif

endmodule

// ===== hdl/double_hash_key_value_table_top.sv =====
// Top level of the double-hash key-value table
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   opcode_i key_i key_len_i value_i
//   out      output     out_valid_o / out_ready_i status_o value_out_o live_count_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (table size)
//
// After reset a clearing pass sweeps every slot of the slot memory; no word is taken.
// One word passes these steps: accept; hash the L key bytes, one a cycle, and one more
// step to see the end; both remainders of the 64-bit hash at four bits a cycle; P probes,
// each a registered read and then a check; load the output register.
// An early answer (full table, get on an empty table, unused opcode) makes P zero.
// The next word is taken while a result waits; a new result holds until the old one leaves.
module double_hash_key_value_table_top #(
  parameter int unsigned DEPTH       = dhkvt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BYTES   = dhkvt_pkg::KEY_BYTES_DEF,
  parameter int unsigned VALUE_WIDTH = dhkvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dhkvt_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dhkvt_pkg::OP_W-1:0]      opcode_i,
  input  logic [dhkvt_pkg::KEY_W-1:0]     key_i,
  input  logic [dhkvt_pkg::KEY_LEN_W-1:0] key_len_i,
  input  logic [dhkvt_pkg::VAL_W-1:0]     value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dhkvt_pkg::STAT_W-1:0]    status_o,
  output logic [dhkvt_pkg::VAL_W-1:0]     value_out_o,
  output logic [dhkvt_pkg::SIZE_W-1:0]    live_count_o
);

  dhkvt_pkg::ctrl_cmd_t cmd;
  dhkvt_pkg::dp_stat_t  stat;

  dhkvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dhkvt_dp #(
    .DEPTH       (DEPTH),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .key_len_i    (key_len_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .value_out_o  (value_out_o),
    .live_count_o (live_count_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
